FILE: design/arpc_pkg.sv
// Shared types and codes for the ARP cache with request retry.
package arpc_pkg;

    // Operation codes carried by an input item.
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_QUEUE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Result kinds carried by an output item.
    localparam logic [2:0] KIND_LOOKUP  = 3'd0;
    localparam logic [2:0] KIND_INSERT  = 3'd1;
    localparam logic [2:0] KIND_QUEUE   = 3'd2;
    localparam logic [2:0] KIND_REMOVE  = 3'd3;
    localparam logic [2:0] KIND_SEND    = 3'd4;
    localparam logic [2:0] KIND_UNREACH = 3'd5;
    localparam logic [2:0] KIND_DONE    = 3'd6;

    // Configuration register indexes.
    localparam logic REG_MAX_SENDS = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [3:0]  port_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [47:0] mac_out;
        logic [31:0] ip_out;
        logic [3:0]  port_out;
        logic [7:0]  waiting_count;
        logic        table_full;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT,
        S_TICK,
        S_AGE
    } state_t;

endpackage

FILE: design/arp_cache_with_request_retry.sv
// Top level of the ARP cache with pending-request retry.

// Each item is handled alone: a lookup passes decode with tag match, a read of
// the MAC memory and the result into the output register; insert, queue, remove
// and clear skip the MAC read. A tick walks the request table one slot a cycle,
// stalling on each notice until the output register is free, then ages every
// cache entry at once.
// IP tags, ages and the request table sit in registers and are matched in
// parallel; MAC addresses live in a synchronous memory with one read port.
// After reset both tables are empty at once; no clearing pass is needed.
module arp_cache_with_request_retry #(
    parameter int CACHE_SLOTS   = 16,
    parameter int REQUEST_SLOTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  arpc_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output arpc_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    localparam int CIDX_W = $clog2(CACHE_SLOTS);
    localparam int RIDX_W = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
    localparam int WALK_W = $clog2(REQUEST_SLOTS + 1);
    localparam logic [WALK_W-1:0] WALK_END = WALK_W'(REQUEST_SLOTS);

    // Control state.
    state_t                   state_reg, state_next;
    logic [3:0]               max_sends_reg;
    logic [7:0]               timeout_reg;
    logic [CACHE_SLOTS-1:0]   entry_valid_reg;
    logic [REQUEST_SLOTS-1:0] pending_valid_reg;
    logic [WALK_W-1:0]        walk_reg;
    logic                     out_valid_reg;
    logic                     look_hit_reg;

    // Payload storage.
    logic [31:0] entry_ip_reg      [CACHE_SLOTS];
    logic [7:0]  entry_age_reg     [CACHE_SLOTS];
    logic [47:0] mac_mem           [CACHE_SLOTS];
    logic [47:0] mac_rd_reg;
    logic [31:0] pending_ip_reg    [REQUEST_SLOTS];
    logic [3:0]  pending_sends_reg [REQUEST_SLOTS];
    logic [3:0]  pending_port_reg  [REQUEST_SLOTS];
    logic [7:0]  pending_packets_reg [REQUEST_SLOTS];
    out_item_t   res_reg;
    out_item_t   out_reg;

    logic              acc;
    logic              out_free;
    logic              c_hit, c_free, r_hit, r_free;
    logic [CIDX_W-1:0] c_hit_idx, c_free_idx, c_slot;
    logic [RIDX_W-1:0] r_hit_idx, r_free_idx, walk_idx;
    logic              walk_unreach;
    logic [7:0]        pkt_sat;
    out_item_t         res_new, notice;
    logic              notice_load;

    assign acc      = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign walk_idx  = walk_reg[RIDX_W-1:0];

    // Tag match and free slot search; the lowest index wins.
    always_comb
    begin
        c_hit = 1'b0; c_hit_idx = '0; c_free = 1'b0; c_free_idx = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--)
        begin
            if (entry_valid_reg[i] && entry_ip_reg[i] == in_item.ip_addr)
            begin
                c_hit = 1'b1; c_hit_idx = CIDX_W'(i);
            end
            if (!entry_valid_reg[i])
            begin
                c_free = 1'b1; c_free_idx = CIDX_W'(i);
            end
        end
        r_hit = 1'b0; r_hit_idx = '0; r_free = 1'b0; r_free_idx = '0;
        for (int i = REQUEST_SLOTS - 1; i >= 0; i--)
        begin
            if (pending_valid_reg[i] && pending_ip_reg[i] == in_item.ip_addr)
            begin
                r_hit = 1'b1; r_hit_idx = RIDX_W'(i);
            end
            if (!pending_valid_reg[i])
            begin
                r_free = 1'b1; r_free_idx = RIDX_W'(i);
            end
        end
        c_slot  = c_hit ? c_hit_idx : c_free_idx;
        pkt_sat = (pending_packets_reg[r_hit_idx] == 8'hFF) ? 8'hFF
                : pending_packets_reg[r_hit_idx] + 8'd1;
    end

    // Result of an accepted item, before any MAC read.
    always_comb
    begin
        res_new = '0;
        res_new.last = 1'b1;
        unique case (in_item.operation)
            OP_LOOKUP: res_new.kind = KIND_LOOKUP;
            OP_INSERT:
            begin
                res_new.kind = KIND_INSERT;
                if (!(c_hit || c_free))
                begin
                    res_new.table_full = 1'b1;
                end
                else if (r_hit)
                begin
                    res_new.hit           = 1'b1;
                    res_new.ip_out        = pending_ip_reg[r_hit_idx];
                    res_new.port_out      = pending_port_reg[r_hit_idx];
                    res_new.waiting_count = pending_packets_reg[r_hit_idx];
                end
            end
            OP_QUEUE:
            begin
                res_new.kind = KIND_QUEUE;
                if (r_hit)
                begin
                    res_new.ip_out        = pending_ip_reg[r_hit_idx];
                    res_new.port_out      = pending_port_reg[r_hit_idx];
                    res_new.waiting_count = pkt_sat;
                end
                else if (r_free)
                begin
                    res_new.ip_out        = in_item.ip_addr;
                    res_new.port_out      = in_item.port_index;
                    res_new.waiting_count = 8'd1;
                end
                else
                begin
                    res_new.table_full = 1'b1;
                end
            end
            OP_REMOVE: res_new.kind = KIND_REMOVE;
            default:   res_new.kind = KIND_DONE;
        endcase
    end

    // Notice for the request slot under the tick walker.
    always_comb
    begin
        walk_unreach = (pending_sends_reg[walk_idx] >= max_sends_reg);
        notice = '0;
        notice.kind          = walk_unreach ? KIND_UNREACH : KIND_SEND;
        notice.ip_out        = pending_ip_reg[walk_idx];
        notice.port_out      = pending_port_reg[walk_idx];
        notice.waiting_count = pending_packets_reg[walk_idx];
        notice_load = (state_reg == S_TICK) && (walk_reg != WALK_END)
                    && pending_valid_reg[walk_idx] && out_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    priority case (in_item.operation)
                        OP_LOOKUP: state_next = S_LOOK;
                        OP_INSERT, OP_QUEUE, OP_REMOVE, OP_CLEAR:
                            state_next = S_EMIT;
                        OP_TICK:   state_next = S_TICK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOK: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (walk_reg == WALK_END)
                begin
                    state_next = S_AGE;
                end
            end
            S_AGE:   state_next = S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers: configuration, valid bits, walker, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sends_reg     <= 4'd5;
            timeout_reg       <= 8'd30;
            entry_valid_reg   <= '0;
            pending_valid_reg <= '0;
            walk_reg          <= '0;
            out_valid_reg     <= 1'b0;
            look_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_SENDS: max_sends_reg <= cfg_data[3:0];
                    REG_TIMEOUT:   timeout_reg   <= cfg_data;
                    default:       max_sends_reg <= max_sends_reg;
                endcase
            end
            if ((state_reg == S_EMIT && out_free) || notice_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (acc)
            begin
                look_hit_reg <= c_hit;
                walk_reg     <= '0;
                unique case (in_item.operation)
                    OP_INSERT:
                    begin
                        if (c_hit || c_free)
                        begin
                            entry_valid_reg[c_slot] <= 1'b1;
                        end
                    end
                    OP_QUEUE:
                    begin
                        if (!r_hit && r_free)
                        begin
                            pending_valid_reg[r_free_idx] <= 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (r_hit)
                        begin
                            pending_valid_reg[r_hit_idx] <= 1'b0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        entry_valid_reg   <= '0;
                        pending_valid_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_TICK && walk_reg != WALK_END)
            begin
                if (!pending_valid_reg[walk_idx] || out_free)
                begin
                    walk_reg <= walk_reg + WALK_W'(1);
                end
                if (notice_load && walk_unreach)
                begin
                    pending_valid_reg[walk_idx] <= 1'b0;
                end
            end
            if (state_reg == S_AGE)
            begin
                for (int i = 0; i < CACHE_SLOTS; i++)
                begin
                    if (entry_valid_reg[i] && ((entry_age_reg[i] == 8'hFF)
                        || (entry_age_reg[i] + 9'd1 >= {1'b0, timeout_reg})))
                    begin
                        entry_valid_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

    // Payload storage, pending result and output register.
    always_ff @(posedge clk)
    begin
        mac_rd_reg <= mac_mem[c_hit_idx];
        if (acc)
        begin
            res_reg <= res_new;
            unique case (in_item.operation)
                OP_INSERT:
                begin
                    if (c_hit || c_free)
                    begin
                        entry_ip_reg[c_slot]  <= in_item.ip_addr;
                        entry_age_reg[c_slot] <= 8'd0;
                        mac_mem[c_slot]       <= in_item.mac_addr;
                    end
                end
                OP_QUEUE:
                begin
                    if (r_hit)
                    begin
                        pending_packets_reg[r_hit_idx] <= pkt_sat;
                    end
                    else if (r_free)
                    begin
                        pending_ip_reg[r_free_idx]      <= in_item.ip_addr;
                        pending_sends_reg[r_free_idx]   <= 4'd0;
                        pending_port_reg[r_free_idx]    <= in_item.port_index;
                        pending_packets_reg[r_free_idx] <= 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_LOOK)
        begin
            res_reg.hit     <= look_hit_reg;
            res_reg.mac_out <= look_hit_reg ? mac_rd_reg : 48'd0;
        end
        if (notice_load && !walk_unreach)
        begin
            pending_sends_reg[walk_idx] <= pending_sends_reg[walk_idx] + 4'd1;
        end
        if (state_reg == S_AGE)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (entry_age_reg[i] != 8'hFF)
                begin
                    entry_age_reg[i] <= entry_age_reg[i] + 8'd1;
                end
            end
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg <= res_reg;
        end
        else if (notice_load)
        begin
            out_reg <= notice;
        end
    end

    // A tick always starts the request walk.
    a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
        acc && in_item.operation == OP_TICK |=> state_reg == S_TICK && walk_reg == '0)
        else $error("tick did not start the request walk");

    // The walker never runs past the end of the request table.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg <= WALK_END)
        else $error("request walker out of range");

    // Only tick notices leave without the last mark.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |->
        out_reg.kind == KIND_SEND || out_reg.kind == KIND_UNREACH)
        else $error("non-notice item without last mark");

    // Clear empties both tables.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc && in_item.operation == OP_CLEAR |=>
        entry_valid_reg == '0 && pending_valid_reg == '0)
        else $error("clear left valid entries");

endmodule
